### sv/mgvf_pkg.sv
package mgvf_pkg;

    // Depth of the task queue between the front and the back. Keep it a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MU     = 3'd0;
    localparam logic [2:0] REG_OLI    = 3'd1;
    localparam logic [2:0] REG_COLS   = 3'd2;
    localparam logic [2:0] REG_ROWS   = 3'd3;
    localparam logic [2:0] REG_TOP    = 3'd4;
    localparam logic [2:0] REG_BOTTOM = 3'd5;

    // Edge classification of one centre pixel.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } edge_flags_t;

    localparam int FLAGS_W = $bits(edge_flags_t);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

endpackage

### sv/mgvf_in_if.sv
interface mgvf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ahead_value;
    logic signed [31:0] image_value;

    modport source (output valid, output ahead_value, output image_value, input ready);
    modport sink   (input valid, input ahead_value, input image_value, output ready);
endinterface

### sv/mgvf_out_if.sv
interface mgvf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_value;
    logic               frame_last;

    modport source (output valid, output new_value, output frame_last, input ready);
    modport sink   (input valid, input new_value, input frame_last, output ready);
endinterface

### sv/mgvf_fifo.sv
module mgvf_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] pop_data
);
    localparam int IW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [IW-1:0] wp_reg, wp_next;
    logic [IW-1:0] rp_reg, rp_next;
    logic [NW-1:0] count_reg, count_next;

    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rp_reg];

    always_comb
    begin
        wp_next    = push ? wp_reg + IW'(1) : wp_reg;
        rp_next    = pop ? rp_reg + IW'(1) : rp_reg;
        count_next = count_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end
endmodule

### sv/mgvf_front.sv
module mgvf_front #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 1024,
    parameter int AW       = 11
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mgvf_in_if.sink                              in_ch,
    input  logic [$clog2(MAX_COLS+1)-1:0]        cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]        rows,
    input  logic                                 top_is_edge,
    input  logic                                 bottom_is_edge,
    output logic                                 wr_en,
    output logic [AW-1:0]                        wr_addr,
    output logic [31:0]                          wr_data,
    input  logic                                 queue_full,
    output logic                                 push,
    output logic [AW-1:0]                        push_head,
    output logic signed [31:0]                   push_image,
    output mgvf_pkg::edge_flags_t                push_flags
);
    import mgvf_pkg::*;

    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int FW  = $clog2(MAX_COLS + 2);
    localparam int CPW = $clog2(MAX_COLS);
    localparam int RPW = $clog2(MAX_ROWS);

    logic [AW-1:0]  head_reg, head_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [CPW-1:0] col_reg, col_next;
    logic [RPW-1:0] row_reg, row_next;
    logic           accept, filling, right, row_last;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && !queue_full;
    assign filling     = fill_reg < (FW'(cols) + FW'(1));
    assign right       = CW'(col_reg) >= (cols - CW'(1));
    assign row_last    = RW'(row_reg) >= (rows - RW'(1));

    assign wr_en      = accept;
    assign wr_addr    = head_reg + AW'(1);
    assign wr_data    = in_ch.ahead_value;
    assign push       = accept && !filling;
    assign push_head  = head_reg + AW'(1);
    assign push_image = in_ch.image_value;

    always_comb
    begin
        push_flags.top    = top_is_edge && (row_reg == '0);
        push_flags.bottom = bottom_is_edge && row_last;
        push_flags.left   = (col_reg == '0);
        push_flags.right  = right;
        push_flags.last   = right && row_last;

        head_next = head_reg;
        fill_next = fill_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept)
        begin
            head_next = head_reg + AW'(1);
            if (filling)
            begin
                fill_next = fill_reg + FW'(1);
            end
            else if (right)
            begin
                col_next = '0;
                if (row_last)
                begin
                    row_next  = '0;
                    fill_next = '0;
                end
                else
                begin
                    row_next = row_reg + RPW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CPW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end
endmodule

### sv/mgvf_back.sv
module mgvf_back #(
    parameter int MAX_COLS = 512,
    parameter int AW       = 11
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(MAX_COLS+1)-1:0]   cols,
    input  logic signed [31:0]              mu_over_lambda,
    input  logic signed [31:0]              one_over_lambda,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic [31:0]                     wr_data,
    input  logic                            task_valid,
    input  logic [AW-1:0]                   task_head,
    input  logic signed [31:0]              task_image,
    input  mgvf_pkg::edge_flags_t           task_flags,
    output logic                            task_pop,
    mgvf_out_if.source                      out_ch
);
    import mgvf_pkg::*;

    localparam int RING = 2 ** AW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MU   = 3'd2;
    localparam logic [2:0] ST_P    = 3'd3;
    localparam logic [2:0] ST_PQ   = 3'd4;
    localparam logic [2:0] ST_T    = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [31:0]        mem [RING];
    logic [31:0]        rd_data_reg;
    logic [AW-1:0]      rd_addr, word_dist;

    logic [2:0]         state_reg, state_next;
    logic [3:0]         step_reg;
    logic [AW-1:0]      head_reg;
    logic signed [31:0] img_reg;
    edge_flags_t        flags_reg;
    logic signed [31:0] c_reg, vhe_reg, p_reg;
    logic signed [36:0] acc_reg;
    logic signed [65:0] prod1_reg;
    logic signed [63:0] prod2_reg;
    logic signed [64:0] prod3_reg;

    logic               out_valid_reg;
    logic signed [31:0] new_value_reg;
    logic               frame_last_reg;
    logic               out_free;

    logic               rep;
    logic signed [32:0] diff;
    logic signed [36:0] term, acc_sum;
    logic signed [33:0] sum_sat;
    logic signed [66:0] r1;
    logic signed [64:0] r2;
    logic signed [65:0] r3;
    logic signed [32:0] diff2;
    logic signed [31:0] vhe_val, p_val, res_val;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.new_value  = new_value_reg;
    assign out_ch.frame_last = frame_last_reg;
    assign out_free          = !out_valid_reg || out_ch.ready;
    assign task_pop          = (state_reg == ST_IDLE) && task_valid;

    // Distance back from the newest word for centre and each neighbour.
    always_comb
    begin
        word_dist = AW'(cols) + AW'(1);
        rep       = 1'b0;
        unique case (step_reg)
            4'd1:
            begin
                word_dist = AW'(cols) + AW'(cols) + AW'(2);
                rep       = flags_reg.top || flags_reg.left;
            end
            4'd2:
            begin
                word_dist = AW'(cols) + AW'(cols) + AW'(1);
                rep       = flags_reg.top;
            end
            4'd3:
            begin
                word_dist = AW'(cols) + AW'(cols);
                rep       = flags_reg.top || flags_reg.right;
            end
            4'd4:
            begin
                word_dist = AW'(cols) + AW'(2);
                rep       = flags_reg.left;
            end
            4'd5:
            begin
                word_dist = AW'(cols);
                rep       = flags_reg.right;
            end
            4'd6:
            begin
                word_dist = AW'(2);
                rep       = flags_reg.bottom || flags_reg.left;
            end
            4'd7:
            begin
                word_dist = AW'(1);
                rep       = flags_reg.bottom;
            end
            4'd8:
            begin
                word_dist = '0;
                rep       = flags_reg.bottom || flags_reg.right;
            end
            default:
            begin
                word_dist = AW'(cols) + AW'(1);
                rep       = 1'b0;
            end
        endcase
    end

    assign rd_addr = head_reg - word_dist;

    // The word read last cycle belongs to the neighbor of the previous step,
    // so its replicate flag is registered along with it.
    logic rep_reg;

    always_comb
    begin
        diff = $signed({rd_data_reg[31], rd_data_reg}) - $signed({c_reg[31], c_reg});
        if (rep_reg)
        begin
            term = '0;
        end
        else if (diff > 33'sd7)
        begin
            term = $signed({{3{diff[32]}}, diff, 1'b0});
        end
        else if (diff > -33'sd7)
        begin
            term = $signed({{4{diff[32]}}, diff});
        end
        else
        begin
            term = '0;
        end
        acc_sum = acc_reg + term;

        if (acc_reg > 37'sd4294967295)
        begin
            sum_sat = 34'sd4294967295;
        end
        else if (acc_reg < -37'sd4294967295)
        begin
            sum_sat = -34'sd4294967295;
        end
        else
        begin
            sum_sat = acc_reg[33:0];
        end

        r1      = ($signed({prod1_reg[65], prod1_reg}) + 67'sd65536) >>> 17;
        vhe_val = sat32(r1[63:0] + $signed({{32{c_reg[31]}}, c_reg}));
        r2      = ($signed({prod2_reg[63], prod2_reg}) + 65'sd32768) >>> 16;
        p_val   = sat32(r2[63:0]);
        diff2   = $signed({vhe_reg[31], vhe_reg}) - $signed({img_reg[31], img_reg});
        r3      = ($signed({prod3_reg[64], prod3_reg}) + 66'sd32768) >>> 16;
        res_val = sat32($signed({{32{vhe_reg[31]}}, vhe_reg}) - r3[63:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (task_valid) state_next = ST_READ;
            ST_READ: if (step_reg == 4'd9) state_next = ST_MU;
            ST_MU:   state_next = ST_P;
            ST_P:    state_next = ST_PQ;
            ST_PQ:   state_next = ST_T;
            ST_T:    state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                step_reg <= step_reg + 4'd1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg <= rep;
        if (task_pop)
        begin
            head_reg  <= task_head;
            img_reg   <= task_image;
            flags_reg <= task_flags;
        end
        if (state_reg == ST_READ)
        begin
            if (step_reg == 4'd1)
            begin
                c_reg   <= rd_data_reg;
                acc_reg <= '0;
            end
            else if (step_reg != 4'd0)
            begin
                acc_reg <= acc_sum;
            end
        end
        if (state_reg == ST_MU)
        begin
            prod1_reg <= mu_over_lambda * sum_sat;
        end
        if (state_reg == ST_P)
        begin
            vhe_reg   <= vhe_val;
            prod2_reg <= one_over_lambda * img_reg;
        end
        if (state_reg == ST_PQ)
        begin
            p_reg <= p_val;
        end
        if (state_reg == ST_T)
        begin
            prod3_reg <= p_reg * diff2;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            new_value_reg  <= res_val;
            frame_last_reg <= flags_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && step_reg == 4'd9) |=> (state_reg == ST_MU))
        else $error("neighbor sweep did not hand over to the multiply steps");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (step_reg <= 4'd9))
        else $error("neighbor step counter ran past the last neighbor");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        task_pop |=> (state_reg == ST_READ && step_reg == 4'd0))
        else $error("task taken without starting a neighbor sweep");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> out_valid_reg)
        else $error("finished result not presented");
endmodule

### sv/mgvf_stencil_stream.sv
// MGVF stencil stream: one motion gradient vector flow update over a raster of
// signed Q16.16 grid values. Each item carries the grid value cols+1 positions
// ahead of the centre pixel and the image sample at the centre; the first cols+1
// items of a frame only fill the window and give no result, every later item
// gives one result, and frame_last marks the final pixel. A front stage writes
// each item into a ring memory and classifies its edges, a four-entry task queue
// follows, and a back sequencer reads the centre and its eight neighbors through
// the single memory read port, one word per cycle, then runs three multiplies in
// turn, taking a new task only when idle again; the front keeps accepting
// items at one per cycle while the queue has room. Registers sit on an APB port
// at byte addresses 4*i and must be written only while the block is idle. The
// window memory has no clearing pass; entries are valid once written.
module mgvf_stencil_stream #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mgvf_in_if.sink     in_ch,
    mgvf_out_if.source  out_ch
);
    import mgvf_pkg::*;

    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    // The ring holds the full window plus every item that can be written while
    // the back still works on older ones (queue, one in flight, a refill).
    localparam int AW   = $clog2(3 * MAX_COLS + QUEUE_DEPTH + 8);
    localparam int TW   = AW + 32 + FLAGS_W;

    logic signed [31:0] mu_reg, oli_reg;
    logic [9:0]         cols_reg;
    logic [10:0]        rows_reg;
    logic               top_reg, bottom_reg;
    logic [CW-1:0]      cols_eff;
    logic [RW-1:0]      rows_eff;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    logic               wr_en, push, full, pop, not_empty;
    logic [AW-1:0]      wr_addr, push_head;
    logic [31:0]        wr_data;
    logic signed [31:0] push_image;
    edge_flags_t        push_flags;
    logic [TW-1:0]      pop_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_MU:     prdata = mu_reg;
            REG_OLI:    prdata = oli_reg;
            REG_COLS:   prdata = {22'd0, cols_reg};
            REG_ROWS:   prdata = {21'd0, rows_reg};
            REG_TOP:    prdata = {31'd0, top_reg};
            REG_BOTTOM: prdata = {31'd0, bottom_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg     <= '0;
            oli_reg    <= '0;
            cols_reg   <= 10'd512;
            rows_reg   <= 11'd1024;
            top_reg    <= 1'b1;
            bottom_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MU:     mu_reg     <= pwdata;
                REG_OLI:    oli_reg    <= pwdata;
                REG_COLS:   cols_reg   <= pwdata[9:0];
                REG_ROWS:   rows_reg   <= pwdata[10:0];
                REG_TOP:    top_reg    <= pwdata[0];
                REG_BOTTOM: bottom_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // Out of range sizes are clamped to what the window supports.
    always_comb
    begin
        if (cols_reg < 10'd4)
        begin
            cols_eff = CW'(4);
        end
        else if (32'(cols_reg) > 32'(MAX_COLS))
        begin
            cols_eff = CW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CW'(cols_reg);
        end
        if (rows_reg < 11'd2)
        begin
            rows_eff = RW'(2);
        end
        else if (32'(rows_reg) > 32'(MAX_ROWS))
        begin
            rows_eff = RW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RW'(rows_reg);
        end
    end

    mgvf_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .cols           (cols_eff),
        .rows           (rows_eff),
        .top_is_edge    (top_reg),
        .bottom_is_edge (bottom_reg),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .queue_full     (full),
        .push           (push),
        .push_head      (push_head),
        .push_image     (push_image),
        .push_flags     (push_flags)
    );

    mgvf_fifo #(
        .W     (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_head, push_image, push_flags}),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    mgvf_back #(
        .MAX_COLS (MAX_COLS),
        .AW       (AW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cols            (cols_eff),
        .mu_over_lambda  (mu_reg),
        .one_over_lambda (oli_reg),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .task_valid      (not_empty),
        .task_head       (pop_data[TW-1 -: AW]),
        .task_image      (pop_data[FLAGS_W +: 32]),
        .task_flags      (pop_data[FLAGS_W-1:0]),
        .task_pop        (pop),
        .out_ch          (out_ch)
    );
endmodule
